### rtl/core/ack_frame_parser_sum16_check_assert.svh
// Assertion macros for the reply-frame parser.
// Expects signals named clk and rst in the scope of each use.
`ifndef ACK_FRAME_PARSER_SUM16_CHECK_ASSERT_SVH
`define ACK_FRAME_PARSER_SUM16_CHECK_ASSERT_SVH

// same-cycle implication
`define AFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/afp_pkg.sv
// Shared types and constants for the reply-frame parser.
// No dependencies.
`default_nettype none

package afp_pkg;

  localparam logic [15:0] MAGIC_VALUE = 16'hEF01;
  localparam logic [7:0]  ACK_ID      = 8'h07;
  localparam logic [15:0] MIN_LENGTH  = 16'd3;

  // header byte positions, counted from zero
  localparam logic [3:0] HDR_MAGIC_HI_POS = 4'd0;
  localparam logic [3:0] HDR_MAGIC_LO_POS = 4'd1;
  localparam logic [3:0] HDR_ID_POS       = 4'd6;
  localparam logic [3:0] HDR_LEN_HI_POS   = 4'd7;
  localparam logic [3:0] HDR_LAST_POS     = 4'd8;

  // frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MAGIC    = 3'd1;
  localparam logic [2:0] ST_ID       = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] rx_byte;
  } afp_item_t;

  typedef struct packed {
    logic       is_end;
    logic [2:0] frame_status;
    logic [7:0] confirm_code;
    logic [7:0] payload_byte;
  } afp_result_t;

endpackage

`default_nettype wire

### rtl/core/afp_in_reg.sv
// Input register for received bytes, one word deep.
// Uses afp_pkg for the item type.
`default_nettype none

module afp_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire afp_pkg::afp_item_t in_item,
  input  wire logic              take,
  output logic                   item_valid,
  output afp_pkg::afp_item_t     item
);

  // refill in the same cycle the parser drains the register
  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/afp_parser.sv
// Header/body parser with sum16 check and result register.
// Uses afp_pkg and the assertion macro header.
`default_nettype none

module afp_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  input  wire afp_pkg::afp_item_t item,
  output logic                    take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output afp_pkg::afp_result_t    out_data
);

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_BODY} phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  header_index, header_index_next;
  logic [15:0] magic_word, magic_word_next;
  logic [7:0]  packet_id, packet_id_next;
  logic [15:0] body_length, body_length_next;
  logic [15:0] body_index, body_index_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  code_byte, code_byte_next;
  logic [7:0]  checksum_high, checksum_high_next;

  logic                 emit;
  afp_pkg::afp_result_t res;

  assign take = item_valid && (!out_valid || out_ready);

  always_comb begin
    logic [7:0]  b;
    logic [3:0]  hi;
    logic [15:0] bi;
    logic [15:0] plen;
    b    = item.rx_byte;
    hi   = header_index;
    bi   = body_index;
    plen = '0;

    phase_next         = phase;
    header_index_next  = header_index;
    magic_word_next    = magic_word;
    packet_id_next     = packet_id;
    body_length_next   = body_length;
    body_index_next    = body_index;
    running_sum_next   = running_sum;
    code_byte_next     = code_byte;
    checksum_high_next = checksum_high;

    emit             = 1'b0;
    res.is_end       = 1'b0;
    res.frame_status = afp_pkg::ST_OK;
    res.confirm_code = 8'd0;
    res.payload_byte = 8'd0;

    if (item.frame_start) begin
      // a frame still open is closed as truncated
      if (phase != PH_IDLE) begin
        emit             = 1'b1;
        res.is_end       = 1'b1;
        res.confirm_code = code_byte;
        res.frame_status = afp_pkg::ST_TRUNC;
      end
      phase_next         = PH_HEADER;
      header_index_next  = '0;
      magic_word_next    = '0;
      packet_id_next     = '0;
      body_length_next   = '0;
      body_index_next    = '0;
      running_sum_next   = '0;
      code_byte_next     = '0;
      checksum_high_next = '0;
      hi                 = '0;
      bi                 = '0;
    end

    case (phase_next)
      PH_HEADER: begin
        case (hi) inside
          afp_pkg::HDR_MAGIC_HI_POS, afp_pkg::HDR_MAGIC_LO_POS: begin
            magic_word_next = {magic_word_next[7:0], b};
          end
          afp_pkg::HDR_ID_POS: begin
            packet_id_next   = b;
            running_sum_next = running_sum_next + {8'd0, b};
          end
          afp_pkg::HDR_LEN_HI_POS, afp_pkg::HDR_LAST_POS: begin
            body_length_next = {body_length_next[7:0], b};
            running_sum_next = running_sum_next + {8'd0, b};
          end
          default: begin
            // address bytes are skipped
          end
        endcase
        header_index_next = hi + 4'd1;
        if (hi >= afp_pkg::HDR_LAST_POS) begin
          phase_next       = PH_IDLE;
          res.is_end       = 1'b1;
          res.confirm_code = code_byte_next;
          emit             = 1'b1;
          if (magic_word_next != afp_pkg::MAGIC_VALUE) begin
            res.frame_status = afp_pkg::ST_MAGIC;
          end else if (packet_id_next != afp_pkg::ACK_ID) begin
            res.frame_status = afp_pkg::ST_ID;
          end else if (body_length_next < afp_pkg::MIN_LENGTH) begin
            res.frame_status = afp_pkg::ST_SHORT;
          end else begin
            emit            = 1'b0;
            res.is_end      = 1'b0;
            res.confirm_code = 8'd0;
            phase_next      = PH_BODY;
            body_index_next = '0;
          end
        end
      end
      PH_BODY: begin
        plen            = body_length_next - 16'd2;
        body_index_next = bi + 16'd1;
        if (bi < plen) begin
          running_sum_next = running_sum_next + {8'd0, b};
          if (bi == 16'd0) begin
            code_byte_next = b;
          end else begin
            emit             = 1'b1;
            res.payload_byte = b;
          end
        end else if (bi == plen) begin
          checksum_high_next = b;
        end else begin
          phase_next       = PH_IDLE;
          emit             = 1'b1;
          res.is_end       = 1'b1;
          res.confirm_code = code_byte_next;
          res.frame_status = ({checksum_high_next, b} == running_sum_next) ?
                             afp_pkg::ST_OK : afp_pkg::ST_CHECKSUM;
        end
      end
      default: begin
        // idle: byte without frame start is dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_index  <= '0;
      magic_word    <= '0;
      packet_id     <= '0;
      body_length   <= '0;
      body_index    <= '0;
      running_sum   <= '0;
      code_byte     <= '0;
      checksum_high <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        header_index  <= header_index_next;
        magic_word    <= magic_word_next;
        packet_id     <= packet_id_next;
        body_length   <= body_length_next;
        body_index    <= body_index_next;
        running_sum   <= running_sum_next;
        code_byte     <= code_byte_next;
        checksum_high <= checksum_high_next;
        out_valid     <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (take && emit) begin
      out_data <= res;
    end
  end

`include "ack_frame_parser_sum16_check_assert.svh"

  `AFP_ASSERT_IMP(a_body_idx_range, phase == PH_BODY, body_index < body_length, "body index past length")
  `AFP_ASSERT_IMP(a_hdr_idx_range, phase == PH_HEADER, header_index <= afp_pkg::HDR_LAST_POS, "header index past last byte")
  `AFP_ASSERT_IMP(a_payload_clean, out_valid && !out_data.is_end, (out_data.frame_status == afp_pkg::ST_OK) && (out_data.confirm_code == 8'd0), "payload word carries status or code")
  `AFP_ASSERT_NEXT(a_restart, take && item.frame_start, (phase == PH_HEADER) && (header_index == 4'd1), "frame start did not restart header")

endmodule

`default_nettype wire

### rtl/core/ack_frame_parser_sum16_check.sv
// Reply-frame parser, top level.
// Slave stream: one received byte per word; tuser flags the first byte of a
//   new expected reply, which restarts the parser.
// Master stream: one word per payload byte (tuser 0) and one closing word
//   per frame (tuser 1) with confirmation code and status.
// Header is magic 0xEF01, four address bytes, id 0x07, 16-bit length (>= 3);
//   body is code, payload, big-endian sum16 over id, length, code and payload.
// A frame start while a frame is open closes it with status truncated.
// Path: an accepted word is held in the input register, then the parse logic
//   writes its result into the result register.
// Throughput: one word per cycle while no result waits on the receiver; each
//   byte needs compares, a 16-bit add and a counter step between the two registers.
// Reset: parser idle, no result pending; bytes are dropped until a frame
//   start arrives.
// Receiver stall: the result register holds; the input register takes one more
//   word only if it is empty, then s_tready drops until the result is taken.
// Depends on afp_pkg, afp_in_reg, afp_parser.
`default_nettype none

module ack_frame_parser_sum16_check (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
  input  wire logic        s_tuser,  // [0] frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // [7:0] payload_byte, [15:8] confirm_code,
                                     // [18:16] frame_status, [23:19] zero
  output logic             m_tuser   // [0] is_end
);

  afp_pkg::afp_item_t   in_item;
  afp_pkg::afp_item_t   item;
  afp_pkg::afp_result_t out_data;
  logic                 item_valid;
  logic                 take;

  assign in_item.rx_byte     = s_tdata;
  assign in_item.frame_start = s_tuser;

  afp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  afp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data)
  );

  assign m_tdata = {5'd0, out_data.frame_status, out_data.confirm_code, out_data.payload_byte};
  assign m_tuser = out_data.is_end;

endmodule

`default_nettype wire

### dv/ack_frame_parser_sum16_check_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the reply-frame parser: directed frames, then random
// well-formed, corrupted, truncated and noise frames with idling on both streams.
// Depends on afp_pkg and ack_frame_parser_sum16_check.

module ack_frame_parser_sum16_check_tb;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_BODY} parse_phase_t;

  localparam int WHOLE_FRAME = 100000;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_WORDS = 260;
  localparam int CALM_AFTER = 200;

  // Tracks the parser state and holds the results it owes.
  class frame_scoreboard;
    parse_phase_t         phase;
    logic [3:0]           hdr_pos;
    logic [15:0]          magic;
    logic [7:0]           pkt_id;
    logic [15:0]          body_len;
    logic [15:0]          body_pos;
    logic [15:0]          sum;
    logic [7:0]           code;
    logic [7:0]           chk_hi;
    afp_pkg::afp_result_t due[$];
    int                   errors;

    function new();
      clear_frame();
      phase = PH_IDLE;
      errors = 0;
    endfunction

    function void clear_frame();
      hdr_pos = '0;
      magic = '0;
      pkt_id = '0;
      body_len = '0;
      body_pos = '0;
      sum = '0;
      code = '0;
      chk_hi = '0;
    endfunction

    function void owe(logic is_end, logic [7:0] payload, logic [2:0] status);
      afp_pkg::afp_result_t r;
      r.is_end = is_end;
      r.payload_byte = payload;
      r.confirm_code = is_end ? code : 8'h00;
      r.frame_status = status;
      due = {due, r};
    endfunction

    function void note_byte(logic [7:0] b, logic fs);
      logic [3:0]  i;
      logic [15:0] pos;
      logic [15:0] plen;
      if (fs) begin
        if (phase != PH_IDLE) owe(1'b1, 8'h00, afp_pkg::ST_TRUNC);
        clear_frame();
        phase = PH_HEADER;
      end
      case (phase)
        PH_HEADER: begin
          i = hdr_pos;
          if (i == afp_pkg::HDR_MAGIC_HI_POS || i == afp_pkg::HDR_MAGIC_LO_POS) begin
            magic = {magic[7:0], b};
          end else if (i == afp_pkg::HDR_ID_POS) begin
            pkt_id = b;
            sum = sum + {8'h00, b};
          end else if (i == afp_pkg::HDR_LEN_HI_POS || i == afp_pkg::HDR_LAST_POS) begin
            body_len = {body_len[7:0], b};
            sum = sum + {8'h00, b};
          end
          hdr_pos = i + 4'd1;
          if (i >= afp_pkg::HDR_LAST_POS) begin
            phase = PH_IDLE;
            if (magic != afp_pkg::MAGIC_VALUE) owe(1'b1, 8'h00, afp_pkg::ST_MAGIC);
            else if (pkt_id != afp_pkg::ACK_ID) owe(1'b1, 8'h00, afp_pkg::ST_ID);
            else if (body_len < afp_pkg::MIN_LENGTH) owe(1'b1, 8'h00, afp_pkg::ST_SHORT);
            else begin
              phase = PH_BODY;
              body_pos = '0;
            end
          end
        end
        PH_BODY: begin
          plen = body_len - 16'd2;
          pos = body_pos;
          body_pos = pos + 16'd1;
          if (pos < plen) begin
            sum = sum + {8'h00, b};
            if (pos == 16'd0) code = b;
            else owe(1'b0, b, afp_pkg::ST_OK);
          end else if (pos == plen) begin
            chk_hi = b;
          end else begin
            phase = PH_IDLE;
            owe(1'b1, 8'h00, ({chk_hi, b} == sum) ? afp_pkg::ST_OK : afp_pkg::ST_CHECKSUM);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [23:0] d, logic u);
      afp_pkg::afp_result_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected word is_end=%0d data=%h", $realtime, u, d);
        return;
      end
      want = due.pop_front();
      if (u !== want.is_end || d[7:0] !== want.payload_byte ||
          d[15:8] !== want.confirm_code || d[18:16] !== want.frame_status) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp is_end=%0d pay=%h code=%h st=%0d, got %0d %h %h %0d",
                   $realtime, want.is_end, want.payload_byte, want.confirm_code,
                   want.frame_status, u, d[7:0], d[15:8], d[18:16]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;

  frame_scoreboard sb = new();
  logic [7:0] frame_bytes[$];
  bit   no_gaps = 1'b0;
  bit   quiet = 1'b0;
  int   stall_left = 0;
  int   dead_cycles = 0;

  ack_frame_parser_sum16_check uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_byte(s_tdata, s_tuser);
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
  end

  // receiver stalls in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && !no_gaps && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) dead_cycles <= 0;
    else dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= STALL_LIMIT) begin
      $display("ack_frame_parser_sum16_check test failed");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic fs);
    if (!quiet && !no_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= fs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // header, body and checksum; only the first cut bytes are kept
  task automatic build_frame(input logic [15:0] mg, input logic [7:0] pid,
                             input logic [15:0] len, input logic [7:0] code,
                             input logic [15:0] flip, input int cut);
    logic [15:0] s;
    logic [7:0]  b;
    logic [15:0] chk;
    int          k;
    frame_bytes.delete();
    frame_bytes = {frame_bytes, mg[15:8]};
    frame_bytes = {frame_bytes, mg[7:0]};
    repeat (4) frame_bytes = {frame_bytes, 8'($urandom)};
    frame_bytes = {frame_bytes, pid};
    frame_bytes = {frame_bytes, len[15:8]};
    frame_bytes = {frame_bytes, len[7:0]};
    s = 16'(pid) + 16'(len[15:8]) + 16'(len[7:0]);
    if (len < afp_pkg::MIN_LENGTH) begin
      repeat (int'(len)) frame_bytes = {frame_bytes, 8'($urandom)};
    end else begin
      for (k = 0; k < int'(len) - 2 && frame_bytes.size() < cut; k++) begin
        b = (k == 0) ? code : 8'($urandom);
        s = s + {8'h00, b};
        frame_bytes = {frame_bytes, b};
      end
      chk = s ^ flip;
      frame_bytes = {frame_bytes, chk[15:8]};
      frame_bytes = {frame_bytes, chk[7:0]};
    end
    while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
  endtask

  task automatic send_frame();
    foreach (frame_bytes[k]) send_word(frame_bytes[k], k == 0);
  endtask

  initial begin
    int          words;
    int          pick;
    logic [15:0] mg;
    logic [7:0]  pid;
    logic [15:0] len;
    logic [15:0] flip;
    int          cut;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray bytes before any frame start are dropped
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    // shortest good frame, then payload with extreme code
    build_frame(afp_pkg::MAGIC_VALUE, afp_pkg::ACK_ID, 16'd3, 8'h00, 16'h0000, WHOLE_FRAME);
    send_frame();
    build_frame(afp_pkg::MAGIC_VALUE, afp_pkg::ACK_ID, 16'd5, 8'hFF, 16'h0000, WHOLE_FRAME);
    send_frame();
    // bad magic; trailing bytes ignored until the next start
    build_frame(16'hEF00, afp_pkg::ACK_ID, 16'd4, 8'h11, 16'h0000, 9);
    send_frame();
    send_word(8'hA5, 1'b0);
    send_word(8'h5A, 1'b0);
    // magic checked ahead of id
    build_frame(16'h10FE, 8'hF8, 16'd4, 8'h22, 16'h0000, 9);
    send_frame();
    build_frame(afp_pkg::MAGIC_VALUE, 8'h08, 16'd4, 8'h33, 16'h0000, 9);
    send_frame();
    build_frame(afp_pkg::MAGIC_VALUE, afp_pkg::ACK_ID, 16'd2, 8'h44, 16'h0000, WHOLE_FRAME);
    send_frame();
    build_frame(afp_pkg::MAGIC_VALUE, afp_pkg::ACK_ID, 16'd0, 8'h44, 16'h0000, WHOLE_FRAME);
    send_frame();
    // checksum off in top and bottom bit
    build_frame(afp_pkg::MAGIC_VALUE, afp_pkg::ACK_ID, 16'd4, 8'h55, 16'h8000, WHOLE_FRAME);
    send_frame();
    build_frame(afp_pkg::MAGIC_VALUE, afp_pkg::ACK_ID, 16'd6, 8'h66, 16'h0001, WHOLE_FRAME);
    send_frame();
    // longest length, cut inside the body; then cut inside the header
    build_frame(afp_pkg::MAGIC_VALUE, afp_pkg::ACK_ID, 16'hFFFF, 8'h77, 16'h0000, 14);
    send_frame();
    build_frame(afp_pkg::MAGIC_VALUE, afp_pkg::ACK_ID, 16'd4, 8'h88, 16'h0000, 5);
    send_frame();
    build_frame(afp_pkg::MAGIC_VALUE, afp_pkg::ACK_ID, 16'd3, 8'h99, 16'h0000, WHOLE_FRAME);
    send_frame();

    words = 0;
    while (words < RANDOM_WORDS) begin
      if (words > CALM_AFTER) quiet = 1'b1;
      no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      mg = afp_pkg::MAGIC_VALUE;
      pid = afp_pkg::ACK_ID;
      flip = 16'h0000;
      cut = WHOLE_FRAME;
      len = 16'($urandom_range(3, 20));
      if ($urandom_range(0, 29) == 0) len = 16'($urandom_range(256, 300));
      if (pick >= 95) begin
        // noise, with the odd frame start
        repeat ($urandom_range(1, 6)) send_word(8'($urandom), $urandom_range(0, 3) == 0);
        continue;
      end
      if (pick >= 89) begin
        if ($urandom_range(0, 1) == 0) len = 16'($urandom_range(3, 65535));
        cut = $urandom_range(1, (len < 20) ? 8 + int'(len) : 28);
      end else if (pick >= 86) begin
        len = 16'($urandom_range(0, 2));
      end else if (pick >= 82) begin
        if ($urandom_range(0, 1) == 0)
          pid = afp_pkg::ACK_ID ^ (8'h01 << $urandom_range(0, 7));
        else pid = 8'($urandom);
      end else if (pick >= 78) begin
        if ($urandom_range(0, 1) == 0)
          mg = afp_pkg::MAGIC_VALUE ^ (16'h0001 << $urandom_range(0, 15));
        else mg = 16'($urandom);
      end else if (pick >= 70) begin
        flip = 16'($urandom_range(1, 65535));
      end
      build_frame(mg, pid, len, 8'($urandom), flip, cut);
      send_frame();
      words += frame_bytes.size();
    end

    s_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("ack_frame_parser_sum16_check test passed");
    end else begin
      $display("ack_frame_parser_sum16_check test failed");
    end
    $finish;
  end

endmodule
